>>> rtl/core/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator core.
// No dependencies; used by ffha_ctrl, ffha_dp and first_fit_heap_allocator_core.
package ffha_pkg;

  localparam int unsigned ArenaBytes  = 4096;
  localparam int unsigned HeaderBytes = 17;
  localparam int unsigned MinCapacity = 24;

  localparam int unsigned AddrW = $clog2(ArenaBytes);
  localparam int unsigned CapW  = AddrW + 1;
  localparam int unsigned NextW = AddrW + 2;
  localparam int unsigned ReqW  = 13;
  localparam int unsigned OffW  = 12;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic            hdr;
    logic            free;
    logic [CapW-1:0] cap;
  } hdr_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_CUR,
    ST_LD_CUR,
    ST_MRG_RD,
    ST_MRG_CHK,
    ST_WB,
    ST_DECIDE,
    ST_SPLIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic ld_req;
    logic rd_cur;
    logic ld_cur;
    logic rd_next;
    logic absorb;
    logic wr_cur;
    logic wr_alloc;
    logic wr_split;
    logic advance;
    logic set_ok;
    logic set_fail;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad_free;
    logic is_free_cmd;
    logic rd_hdr;
    logic rd_free;
    logic cur_free;
    logic next_in;
    logic fit;
    logic split;
    logic out_busy;
  } dp_status_t;

endpackage

>>> rtl/core/ffha_ctrl.sv
// Controller state machine of the heap allocator: sequences clear, walk, merge and split.
// Depends on ffha_pkg; drives ffha_dp through ctrl_cmd_t and reads dp_status_t.
module ffha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ffha_pkg::dp_status_t status_i,
  output ffha_pkg::ctrl_cmd_t  cmd_o
);

  ffha_pkg::state_e state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == ffha_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffha_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = ffha_pkg::ST_IDLE;
      end
      ffha_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = status_i.bad_free ? ffha_pkg::ST_RESP : ffha_pkg::ST_RD_CUR;
        end
      end
      ffha_pkg::ST_RD_CUR: state_d = ffha_pkg::ST_LD_CUR;
      ffha_pkg::ST_LD_CUR: begin
        state_d = status_i.rd_hdr ? ffha_pkg::ST_MRG_RD : ffha_pkg::ST_RESP;
      end
      ffha_pkg::ST_MRG_RD: begin
        state_d = (status_i.cur_free && status_i.next_in) ? ffha_pkg::ST_MRG_CHK
                                                          : ffha_pkg::ST_WB;
      end
      ffha_pkg::ST_MRG_CHK: begin
        state_d = (status_i.rd_hdr && status_i.rd_free) ? ffha_pkg::ST_MRG_RD
                                                        : ffha_pkg::ST_WB;
      end
      ffha_pkg::ST_WB: begin
        state_d = status_i.is_free_cmd ? ffha_pkg::ST_RESP : ffha_pkg::ST_DECIDE;
      end
      ffha_pkg::ST_DECIDE: begin
        if (status_i.cur_free && status_i.fit) begin
          state_d = status_i.split ? ffha_pkg::ST_SPLIT : ffha_pkg::ST_RESP;
        end else if (status_i.next_in) begin
          state_d = ffha_pkg::ST_RD_CUR;
        end else begin
          state_d = ffha_pkg::ST_RESP;
        end
      end
      ffha_pkg::ST_SPLIT: state_d = ffha_pkg::ST_RESP;
      ffha_pkg::ST_RESP: begin
        if (!status_i.out_busy) state_d = ffha_pkg::ST_IDLE;
      end
      default: state_d = ffha_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ffha_pkg::ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ffha_pkg::ST_IDLE: begin
        cmd_o.ld_req   = accept;
        cmd_o.set_fail = accept && status_i.bad_free;
      end
      ffha_pkg::ST_RD_CUR: cmd_o.rd_cur = 1'b1;
      ffha_pkg::ST_LD_CUR: begin
        cmd_o.ld_cur   = status_i.rd_hdr;
        cmd_o.set_fail = !status_i.rd_hdr;
      end
      ffha_pkg::ST_MRG_RD: cmd_o.rd_next = status_i.cur_free && status_i.next_in;
      ffha_pkg::ST_MRG_CHK: cmd_o.absorb = status_i.rd_hdr && status_i.rd_free;
      ffha_pkg::ST_WB: begin
        cmd_o.wr_cur = 1'b1;
        cmd_o.set_ok = status_i.is_free_cmd;
      end
      ffha_pkg::ST_DECIDE: begin
        if (status_i.cur_free && status_i.fit) begin
          cmd_o.wr_alloc = 1'b1;
          cmd_o.set_ok   = !status_i.split;
        end else if (status_i.next_in) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.set_fail = 1'b1;
        end
      end
      ffha_pkg::ST_SPLIT: begin
        cmd_o.wr_split = 1'b1;
        cmd_o.set_ok   = 1'b1;
      end
      ffha_pkg::ST_RESP: cmd_o.emit = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ffha_pkg::ST_CLEAR) |=> (state_q != ffha_pkg::ST_CLEAR))
    else $error("clearing pass re-entered");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ffha_pkg::ST_RD_CUR || state_q == ffha_pkg::ST_RESP))
    else $error("accepted transaction did not start a walk or reply");

  a_emit_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == ffha_pkg::ST_IDLE))
    else $error("reply issued without returning to idle");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_wr, cmd_o.absorb, cmd_o.wr_cur, cmd_o.wr_alloc, cmd_o.wr_split}))
    else $error("more than one header write in a cycle");

endmodule

>>> rtl/core/ffha_dp.sv
// Datapath of the heap allocator: header memory, walk registers and reply register.
// Depends on ffha_pkg; controlled by ffha_ctrl.
module ffha_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffha_pkg::ctrl_cmd_t           cmd_i,
  output ffha_pkg::dp_status_t          status_o,
  input  logic                          cmd_bit_i,
  input  logic [ffha_pkg::ReqW-1:0]     request_bytes_i,
  input  logic [ffha_pkg::OffW-1:0]     payload_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          granted_o,
  output logic [ffha_pkg::OffW-1:0]     result_offset_o
);

  localparam int unsigned AW = ffha_pkg::AddrW;
  localparam int unsigned CW = ffha_pkg::CapW;
  localparam int unsigned NW = ffha_pkg::NextW;

  ffha_pkg::hdr_entry_t mem [ffha_pkg::ArenaBytes];
  ffha_pkg::hdr_entry_t rdata_q, wr_data, reset_entry;

  logic [AW-1:0] clr_q, b_q, rd_addr, wr_addr;
  logic          wr_en, rd_en;
  logic          cmd_free_q, cur_free_q;
  logic [CW-1:0] cur_cap_q, q_q, req_min;
  logic [NW-1:0] next_addr, split_need, split_addr;
  logic          res_ok_q, out_valid_q, granted_q;
  logic [ffha_pkg::OffW-1:0] off_q;

  assign next_addr  = NW'(b_q) + NW'(ffha_pkg::HeaderBytes) + NW'(cur_cap_q);
  assign split_need = NW'(q_q) + NW'(ffha_pkg::HeaderBytes) + NW'(ffha_pkg::MinCapacity);
  assign split_addr = NW'(b_q) + NW'(ffha_pkg::HeaderBytes) + NW'(q_q);
  assign req_min    = (CW'(request_bytes_i) < CW'(ffha_pkg::MinCapacity))
                      ? CW'(ffha_pkg::MinCapacity) : CW'(request_bytes_i);

  always_comb begin
    reset_entry      = '0;
    reset_entry.hdr  = 1'b1;
    reset_entry.free = 1'b1;
    reset_entry.cap  = CW'(ffha_pkg::ArenaBytes - ffha_pkg::HeaderBytes);
  end

  // Header memory: one write port, one registered read port
  assign rd_en   = cmd_i.rd_cur || cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_next ? next_addr[AW-1:0] : b_q;
  assign wr_en   = cmd_i.clr_wr || cmd_i.absorb || cmd_i.wr_cur
                   || cmd_i.wr_alloc || cmd_i.wr_split;

  always_comb begin
    wr_addr = b_q;
    wr_data = '0;
    priority if (cmd_i.clr_wr) begin
      wr_addr = clr_q;
      wr_data = (clr_q == '0) ? reset_entry : '0;
    end else if (cmd_i.absorb) begin
      wr_addr = next_addr[AW-1:0];
    end else if (cmd_i.wr_cur) begin
      wr_data = '{hdr: 1'b1, free: cur_free_q, cap: cur_cap_q};
    end else if (cmd_i.wr_alloc) begin
      wr_data = '{hdr: 1'b1, free: 1'b0,
                  cap: (split_need <= NW'(cur_cap_q)) ? q_q : cur_cap_q};
    end else if (cmd_i.wr_split) begin
      wr_addr = split_addr[AW-1:0];
      wr_data = '{hdr: 1'b1, free: 1'b1,
                  cap: CW'(cur_cap_q - q_q - CW'(ffha_pkg::HeaderBytes))};
    end else begin
      wr_addr = b_q;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      cmd_free_q <= (cmd_bit_i == ffha_pkg::CmdFree);
      q_q        <= req_min;
      b_q        <= (cmd_bit_i == ffha_pkg::CmdFree)
                    ? AW'(payload_offset_i - ffha_pkg::OffW'(ffha_pkg::HeaderBytes)) : '0;
    end else if (cmd_i.advance) begin
      b_q <= next_addr[AW-1:0];
    end
    if (cmd_i.ld_cur) begin
      cur_free_q <= cmd_free_q || rdata_q.free;
      cur_cap_q  <= rdata_q.cap;
    end else if (cmd_i.absorb) begin
      cur_cap_q <= CW'(cur_cap_q + CW'(ffha_pkg::HeaderBytes) + rdata_q.cap);
    end
    if (cmd_i.set_ok) res_ok_q <= 1'b1;
    else if (cmd_i.set_fail) res_ok_q <= 1'b0;
  end

  // Reply register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      granted_q <= res_ok_q;
      off_q     <= (res_ok_q && !cmd_free_q)
                   ? ffha_pkg::OffW'(b_q + AW'(ffha_pkg::HeaderBytes)) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign result_offset_o = off_q;

  always_comb begin
    status_o             = '0;
    status_o.clr_last    = (clr_q == AW'(ffha_pkg::ArenaBytes - 1));
    status_o.bad_free    = (cmd_bit_i == ffha_pkg::CmdFree)
                           && (payload_offset_i < ffha_pkg::OffW'(ffha_pkg::HeaderBytes));
    status_o.is_free_cmd = cmd_free_q;
    status_o.rd_hdr      = rdata_q.hdr;
    status_o.rd_free     = rdata_q.free;
    status_o.cur_free    = cur_free_q;
    status_o.next_in     = (next_addr < NW'(ffha_pkg::ArenaBytes));
    status_o.fit         = (cur_cap_q >= q_q);
    status_o.split       = (split_need <= NW'(cur_cap_q));
    status_o.out_busy    = out_valid_q && !out_ready_i;
  end

endmodule

>>> rtl/core/first_fit_heap_allocator_core.sv
// First-fit heap allocator with block split and forward coalescing, top level.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | cmd_i, request_bytes_i, payload_offset_i
//   out     | output    | out_valid_o / out_ready_i| granted_o, result_offset_o
//
// After reset, a clearing pass writes all 4096 header entries, one per cycle;
// no transaction is taken until it ends.
// One transaction at a time: the header memory, with one write and one read port, is walked
// block by block. An allocate merges free blocks that follow each block visited, then may
// split the chosen block and replies; a free merges forward before its reply.
// The reply register holds a result while the next transaction is taken; a new
// reply waits only if the previous one has not been taken by then.
module first_fit_heap_allocator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [ffha_pkg::ReqW-1:0] request_bytes_i,
  input  logic [ffha_pkg::OffW-1:0] payload_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      granted_o,
  output logic [ffha_pkg::OffW-1:0] result_offset_o
);

  // Command and status between controller and datapath
  ffha_pkg::ctrl_cmd_t  ctrl_cmd;
  ffha_pkg::dp_status_t dp_status;

  // Sequence clear, walk, merge, split and reply
  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // Hold header memory, current block and the reply register
  ffha_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .cmd_bit_i        (cmd_i),
    .request_bytes_i  (request_bytes_i),
    .payload_offset_i (payload_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_o        (granted_o),
    .result_offset_o  (result_offset_o)
  );

endmodule

>>> tb/sv/ffha_checker.sv
`timescale 1ns / 1ps
// Scoreboard for first_fit_heap_allocator_core: watches both channels, predicts replies
// with its own block-chain model and compares them. Depends on ffha_pkg only.
module ffha_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      cmd_i,
  input  logic [ffha_pkg::ReqW-1:0] request_bytes_i,
  input  logic [ffha_pkg::OffW-1:0] payload_offset_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      granted_i,
  input  logic [ffha_pkg::OffW-1:0] result_offset_i,
  output int                        mismatch_cnt_o,
  output int                        pending_cnt_o
);

  typedef struct packed {
    logic                      granted;
    logic [ffha_pkg::OffW-1:0] offset;
  } reply_t;

  bit          blk_hdr [ffha_pkg::ArenaBytes];
  bit          blk_free[ffha_pkg::ArenaBytes];
  int unsigned blk_cap [ffha_pkg::ArenaBytes];
  reply_t      reply_q[$];
  int          mismatches;

  function automatic int unsigned block_end(int unsigned b);
    return b + ffha_pkg::HeaderBytes + blk_cap[b];
  endfunction

  function automatic bit follows(int unsigned b);
    int unsigned n;
    n = block_end(b);
    return n < ffha_pkg::ArenaBytes && blk_hdr[n];
  endfunction

  function automatic void coalesce(int unsigned b);
    int unsigned n;
    while (blk_free[b] && follows(b)) begin
      n = block_end(b);
      if (!blk_free[n]) break;
      blk_cap[b] += ffha_pkg::HeaderBytes + blk_cap[n];
      blk_hdr[n] = 0;
      blk_free[n] = 0;
      blk_cap[n] = 0;
    end
  endfunction

  function automatic void clear_arena();
    foreach (blk_hdr[i]) begin
      blk_hdr[i] = 0;
      blk_free[i] = 0;
      blk_cap[i] = 0;
    end
    blk_hdr[0] = 1;
    blk_free[0] = 1;
    blk_cap[0] = ffha_pkg::ArenaBytes - ffha_pkg::HeaderBytes;
  endfunction

  function automatic reply_t first_fit(int unsigned req);
    int unsigned q, b, c, n;
    reply_t r;
    r = '0;
    q = (req < ffha_pkg::MinCapacity) ? ffha_pkg::MinCapacity : req;
    b = 0;
    forever begin
      coalesce(b);
      if (blk_free[b] && blk_cap[b] >= q) begin
        c = blk_cap[b];
        if (q + ffha_pkg::HeaderBytes + ffha_pkg::MinCapacity <= c) begin
          blk_cap[b] = q;
          n = block_end(b);
          blk_hdr[n] = 1;
          blk_free[n] = 1;
          blk_cap[n] = c - q - ffha_pkg::HeaderBytes;
        end
        blk_free[b] = 0;
        r.granted = 1'b1;
        r.offset = ffha_pkg::OffW'(b + ffha_pkg::HeaderBytes);
        return r;
      end
      if (!follows(b)) return r;
      b = block_end(b);
    end
  endfunction

  function automatic reply_t release_block(int unsigned p);
    int unsigned h;
    reply_t r;
    r = '0;
    if (p < ffha_pkg::HeaderBytes) return r;
    h = p - ffha_pkg::HeaderBytes;
    if (h >= ffha_pkg::ArenaBytes || !blk_hdr[h]) return r;
    blk_free[h] = 1;
    coalesce(h);
    r.granted = 1'b1;
    return r;
  endfunction

  initial begin
    clear_arena();
    mismatches = 0;
  end

  assign mismatch_cnt_o = mismatches;
  assign pending_cnt_o  = reply_q.size();

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == ffha_pkg::CmdAlloc) reply_q.push_back(first_fit(request_bytes_i));
        else reply_q.push_back(release_block(payload_offset_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: granted=%0d offset=%0d", granted_i, result_offset_i);
        end else begin
          want = reply_q.pop_front();
          if (want.granted !== granted_i || want.offset !== result_offset_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: expected granted=%0d offset=%0d, got granted=%0d offset=%0d",
                       want.granted, want.offset, granted_i, result_offset_i);
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus and verdict.
// Depends on ffha_pkg, first_fit_heap_allocator_core and ffha_checker.
module testbench;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned RandomReqs = 800;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      cmd_i = ffha_pkg::CmdAlloc;
  logic [ffha_pkg::ReqW-1:0] request_bytes_i = '0;
  logic [ffha_pkg::OffW-1:0] payload_offset_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      granted_o;
  logic [ffha_pkg::OffW-1:0] result_offset_o;
  int                        mismatch_cnt, pending_cnt;
  int unsigned               cycle_cnt = 0;
  bit                        calm_out = 1'b0;

  // Bookkeeping of what the block has handed out, used to aim frees.
  logic        sent_cmd_q[$];
  logic [ffha_pkg::OffW-1:0] live_q[$];
  logic [ffha_pkg::OffW-1:0] dead_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  first_fit_heap_allocator_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .request_bytes_i,
    .payload_offset_i, .out_valid_o, .out_ready_i, .granted_o, .result_offset_o
  );

  ffha_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .request_bytes_i,
    .payload_offset_i, .out_valid_i(out_valid_o), .out_ready_i, .granted_i(granted_o),
    .result_offset_i(result_offset_o), .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o(pending_cnt)
  );

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Track granted payloads so frees mostly hit real blocks.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i && sent_cmd_q.size() > 0) begin
      if (sent_cmd_q.pop_front() == ffha_pkg::CmdAlloc && granted_o)
        live_q.push_back(result_offset_o);
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Stall the reply channel; calm phases keep ready high.
  always @(negedge clk_i) begin
    int unsigned g;
    if (calm_out || !rst_ni) begin
      out_ready_i <= rst_ni;
    end else begin
      g = gap_len();
      if (g == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // Drive one transaction and hold it until accepted; idle first if asked.
  task automatic issue(input logic op, input int unsigned nbytes, input int unsigned poff,
                       input bit idle);
    int unsigned g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= op;
    request_bytes_i <= ffha_pkg::ReqW'(nbytes);
    payload_offset_i <= ffha_pkg::OffW'(poff);
    sent_cmd_q.push_back(op);
    #1;
    while (!in_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    if (op == ffha_pkg::CmdFree) dead_q.push_back(ffha_pkg::OffW'(poff));
  endtask

  task automatic free_live(input int unsigned idx, input bit idle);
    logic [ffha_pkg::OffW-1:0] p;
    p = live_q[idx];
    live_q.delete(idx);
    issue(ffha_pkg::CmdFree, 0, p, idle);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_cnt != 0 || sent_cmd_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned r, sz;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: small and zero requests, exact minimum, oversize and max field.
    calm_out = 1'b1;
    issue(ffha_pkg::CmdAlloc, 0, 0, 0);
    issue(ffha_pkg::CmdAlloc, 23, 0, 0);
    issue(ffha_pkg::CmdAlloc, 24, 0, 0);
    issue(ffha_pkg::CmdAlloc, 4096, 0, 0);
    issue(ffha_pkg::CmdAlloc, 8191, 0, 0);
    // Bad frees: below header size, zero, top offset, not a header start.
    issue(ffha_pkg::CmdFree, 0, 0, 0);
    issue(ffha_pkg::CmdFree, 0, 16, 0);
    issue(ffha_pkg::CmdFree, 0, 4095, 0);
    issue(ffha_pkg::CmdFree, 0, ffha_pkg::HeaderBytes + 1, 0);
    drain();
    // Free middle then first: merge forward on free, double free.
    issue(ffha_pkg::CmdFree, 0, 2 * ffha_pkg::HeaderBytes + 24, 0);
    issue(ffha_pkg::CmdFree, 0, ffha_pkg::HeaderBytes, 0);
    issue(ffha_pkg::CmdFree, 0, ffha_pkg::HeaderBytes, 0);
    issue(ffha_pkg::CmdFree, 0, 3 * ffha_pkg::HeaderBytes + 48, 0);
    // Whole arena in one block, then split remainder edges.
    issue(ffha_pkg::CmdAlloc, ffha_pkg::ArenaBytes - ffha_pkg::HeaderBytes, 0, 0);
    issue(ffha_pkg::CmdAlloc, 1, 0, 0);
    issue(ffha_pkg::CmdFree, 0, ffha_pkg::HeaderBytes, 0);
    issue(ffha_pkg::CmdAlloc, ffha_pkg::ArenaBytes - 2 * ffha_pkg::HeaderBytes - 24, 0, 0);
    issue(ffha_pkg::CmdAlloc, 24, 0, 0);
    issue(ffha_pkg::CmdFree, 0, ffha_pkg::HeaderBytes, 0);
    issue(ffha_pkg::CmdAlloc, ffha_pkg::ArenaBytes - 2 * ffha_pkg::HeaderBytes - 23, 0, 0);
    issue(ffha_pkg::CmdFree, 0, ffha_pkg::HeaderBytes, 0);
    issue(ffha_pkg::CmdFree, 0, ffha_pkg::ArenaBytes - 24, 0);
    drain();
    live_q.delete();
    calm_out = 1'b0;

    for (int unsigned i = 0; i < RandomReqs; i++) begin
      // Alternate idle-free stretches with gappy ones.
      bit idle;
      idle = ((i / 100) % 2) == 1;
      calm_out = ((i / 150) % 3) == 2;
      if (i == 400) drain();
      r = $urandom_range(0, 99);
      if (r < 50 || (r < 80 && live_q.size() == 0)) begin
        sz = $urandom_range(0, 99);
        if (sz < 60) sz = $urandom_range(0, 120);
        else if (sz < 90) sz = $urandom_range(121, 600);
        else sz = $urandom_range(601, 8191);
        issue(ffha_pkg::CmdAlloc, sz, 0, idle);
      end else if (r < 80) begin
        free_live($urandom_range(0, live_q.size() - 1), idle);
      end else if (r < 88 && dead_q.size() > 0) begin
        issue(ffha_pkg::CmdFree, 0, dead_q[$urandom_range(0, dead_q.size() - 1)], idle);
      end else begin
        issue(ffha_pkg::CmdFree, 0, $urandom_range(0, 4095), idle);
      end
    end

    drain();
    calm_out = 1'b1;
    repeat (50) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
